// ===== rtl/core/gscs_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the golden-section cubic search block.
// Depends on nothing; imported by golden_section_cubic_search_top.
package gscs_pkg;

    // Default fixed-point format and iteration limit.
    localparam int FRAC_BITS_DEF      = 16;
    localparam int MAX_ITERATIONS_DEF = 63;

    // Field widths.
    localparam int DATA_W   = 32;
    localparam int ITER_W   = 6;
    localparam int CFG_IDX_W = 3;

    // Golden ratio r and 1-r as unsigned 0.32 fractions.
    localparam logic [31:0] R_FRAC           = 32'd2654435769;
    localparam logic [31:0] ONE_MINUS_R_FRAC = 32'd1640531527;

    // Register reset values.
    localparam logic [31:0] COEF_CUBIC_RST    = 32'hFFFF_0000;  // -1.0
    localparam logic [31:0] COEF_SQUARE_RST   = 32'hFFFA_0000;  // -6.0
    localparam logic [31:0] COEF_LINEAR_RST   = 32'h0001_0000;  //  1.0
    localparam logic [31:0] COEF_CONSTANT_RST = 32'h0006_0000;  //  6.0
    localparam logic [ITER_W-1:0] ITER_RST    = 6'd6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_COEF_CUBIC    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_SQUARE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_LINEAR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_CONSTANT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_COUNT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEEK_MAXIMUM  = 3'd5;

    // Horner step indexes: which coefficient is added after each multiply.
    localparam logic [1:0] STEP_SQUARE   = 2'd0;
    localparam logic [1:0] STEP_LINEAR   = 2'd1;
    localparam logic [1:0] STEP_CONSTANT = 2'd2;

endpackage

// ===== rtl/core/golden_section_cubic_search_top.sv =====
`timescale 1ns / 1ps
// Golden-section search on a configurable cubic, one shared multiplier.
// Depends on gscs_pkg.
//
// Each input transaction carries a signed Q16.16 interval (left bound in the
// low word, right bound in the high word; swapped bounds are exchanged). The
// block places two probes at fractions 1-r and r of the interval, evaluates
// the cubic c3*x^3 + c2*x^2 + c1*x + c0 at each by Horner's rule, and then
// narrows the interval iteration_count times (limited to MAX_ITERATIONS),
// keeping one probe and evaluating one new probe per iteration. The output
// transaction carries the final upper probe, the cubic value there, and a
// flag that is set when any Horner step of this search saturated to the
// signed 32-bit range. seek_maximum = 0 searches a minimum, 1 a maximum.
// Every multiply runs through a single 33x33-bit signed multiplier whose
// product is registered: placing a probe takes a multiply and an add state,
// and each cubic evaluation three multiply/add-and-saturate pairs.
// s_axis_tready is high only while no search is running, so the block
// takes no new interval before the current search has finished.
// A finished result sits in the output register until taken, and the next
// interval may be accepted while it waits. Configuration registers are
// written through i_cfg_we / i_cfg_addr / i_cfg_data and must only change
// while the block is idle.

module golden_section_cubic_search_top #(
    parameter int FRAC_BITS      = gscs_pkg::FRAC_BITS_DEF,
    parameter int MAX_ITERATIONS = gscs_pkg::MAX_ITERATIONS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [gscs_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [gscs_pkg::DATA_W-1:0]     i_cfg_data,
    // Input stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] left_bound, [63:32] right_bound
    input  logic [63:0]                     s_axis_tdata,
    // Output stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] best_point, [63:32] best_value, [64] value_saturated, [71:65] zero
    output logic [71:0]                     m_axis_tdata
);

    import gscs_pkg::*;

    // Iteration counter width follows the limit; the compare against the
    // 6-bit register runs at the wider of the two widths.
    localparam int IW = $clog2(MAX_ITERATIONS + 1);
    localparam int CW = (IW > ITER_W) ? IW : ITER_W;

    localparam logic signed [64:0] SAT_HI = 65'sd2147483647;
    localparam logic signed [64:0] SAT_LO = -65'sd2147483648;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PMUL,    // width * fraction
        ST_PADD,    // probe = left + high word of product
        ST_HMUL,    // accumulator * probe
        ST_HADD,    // floor shift, add coefficient, saturate
        ST_DECIDE,  // drop one side of the interval
        ST_DONE     // hand the result to the output register
    } t_state;

    // Configuration registers.
    logic signed [DATA_W-1:0] r_coef_cubic;
    logic signed [DATA_W-1:0] r_coef_square;
    logic signed [DATA_W-1:0] r_coef_linear;
    logic signed [DATA_W-1:0] r_coef_constant;
    logic [ITER_W-1:0]        r_iter_count;
    logic                     r_seek_max;

    // Sequencer and search state.
    t_state                   r_state;
    logic                     r_m_valid;
    logic                     r_init;     // still placing the first two probes
    logic                     r_target;   // 0: new probe is the lower, 1: upper
    logic [1:0]               r_step;
    logic [IW-1:0]            r_iter;

    // Datapath registers.
    logic signed [DATA_W-1:0] r_a;
    logic signed [DATA_W-1:0] r_b;
    logic signed [DATA_W-1:0] r_x0;
    logic signed [DATA_W-1:0] r_x1;
    logic signed [DATA_W-1:0] r_f0;
    logic signed [DATA_W-1:0] r_f1;
    logic signed [DATA_W-1:0] r_acc;
    logic [63:0]              r_prod;
    logic                     r_sat;
    logic [71:0]              r_m_data;

    logic signed [DATA_W-1:0] w_left;
    logic signed [DATA_W-1:0] w_right;
    logic [IW-1:0]            w_iter_lim;
    logic [DATA_W-1:0]        w_width;
    logic [DATA_W-1:0]        w_frac;
    logic signed [DATA_W-1:0] w_xsel;
    logic signed [32:0]       w_mul_a;
    logic signed [32:0]       w_mul_b;
    logic signed [65:0]       w_mul_p;
    logic signed [DATA_W-1:0] w_probe;
    logic signed [63:0]       w_shift;
    logic signed [DATA_W-1:0] w_coef;
    logic signed [64:0]       w_sum;
    logic signed [DATA_W-1:0] w_hval;
    logic                     w_hsat;
    logic                     w_move_left;
    logic                     w_accept;
    logic                     w_out_free;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;
    assign w_left     = s_axis_tdata[31:0];
    assign w_right    = s_axis_tdata[63:32];

    assign w_iter_lim = (CW'(r_iter_count) > CW'(MAX_ITERATIONS)) ?
                        IW'(MAX_ITERATIONS) : IW'(r_iter_count);

    // The interval is kept ordered, so the difference is a nonnegative
    // value below 2^32 and its low word is exact as an unsigned number.
    assign w_width = DATA_W'(r_b - r_a);
    assign w_frac  = r_target ? R_FRAC : ONE_MINUS_R_FRAC;
    assign w_xsel  = r_target ? r_x1 : r_x0;

    // Shared multiplier: unsigned width times fraction while placing a probe,
    // signed accumulator times probe during Horner steps.
    always_comb begin
        if (r_state == ST_PMUL) begin
            w_mul_a = {1'b0, w_width};
            w_mul_b = {1'b0, w_frac};
        end else begin
            w_mul_a = {r_acc[DATA_W-1], r_acc};
            w_mul_b = {w_xsel[DATA_W-1], w_xsel};
        end
    end
    assign w_mul_p = w_mul_a * w_mul_b;

    assign w_probe = r_a + $signed(r_prod[63:32]);

    always_comb begin
        unique case (r_step)
            STEP_SQUARE: w_coef = r_coef_square;
            STEP_LINEAR: w_coef = r_coef_linear;
            default:     w_coef = r_coef_constant;
        endcase
    end

    // Arithmetic shift is the floor division by 2^FRAC_BITS.
    assign w_shift = $signed(r_prod) >>> FRAC_BITS;
    assign w_sum   = {w_shift[63], w_shift} + {{33{w_coef[DATA_W-1]}}, w_coef};

    always_comb begin
        w_hsat = 1'b1;
        if (w_sum > SAT_HI) begin
            w_hval = SAT_HI[DATA_W-1:0];
        end else if (w_sum < SAT_LO) begin
            w_hval = SAT_LO[DATA_W-1:0];
        end else begin
            w_hval = w_sum[DATA_W-1:0];
            w_hsat = 1'b0;
        end
    end

    // Minimizing moves the left bound on ties; maximizing moves the right.
    assign w_move_left = r_seek_max ? (r_f0 < r_f1) : (r_f0 >= r_f1);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_cubic    <= COEF_CUBIC_RST;
            r_coef_square   <= COEF_SQUARE_RST;
            r_coef_linear   <= COEF_LINEAR_RST;
            r_coef_constant <= COEF_CONSTANT_RST;
            r_iter_count    <= ITER_RST;
            r_seek_max      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_COEF_CUBIC:    r_coef_cubic    <= i_cfg_data;
                REG_COEF_SQUARE:   r_coef_square   <= i_cfg_data;
                REG_COEF_LINEAR:   r_coef_linear   <= i_cfg_data;
                REG_COEF_CONSTANT: r_coef_constant <= i_cfg_data;
                REG_ITER_COUNT:    r_iter_count    <= i_cfg_data[ITER_W-1:0];
                REG_SEEK_MAXIMUM:  r_seek_max      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer state and the output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
            r_init    <= 1'b0;
            r_target  <= 1'b0;
            r_step    <= STEP_SQUARE;
            r_iter    <= '0;
        end else begin
            // In ST_DONE the valid flag is handled by the state arm below.
            if (r_m_valid && m_axis_tready && r_state != ST_DONE) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_init   <= 1'b1;
                        r_target <= 1'b0;
                        r_iter   <= w_iter_lim;
                        r_state  <= ST_PMUL;
                    end
                end
                ST_PMUL: begin
                    r_state <= ST_PADD;
                end
                ST_PADD: begin
                    r_step  <= STEP_SQUARE;
                    r_state <= ST_HMUL;
                end
                ST_HMUL: begin
                    r_state <= ST_HADD;
                end
                ST_HADD: begin
                    if (r_step != STEP_CONSTANT) begin
                        r_step  <= r_step + 2'd1;
                        r_state <= ST_HMUL;
                    end else if (r_init && !r_target) begin
                        r_target <= 1'b1;
                        r_state  <= ST_PMUL;
                    end else begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    r_init <= 1'b0;
                    if (r_iter == '0) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_iter   <= r_iter - IW'(1);
                        r_target <= w_move_left;
                        r_state  <= ST_PMUL;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers; none of them needs a reset.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_accept) begin
            r_sat <= 1'b0;
            if (w_left > w_right) begin
                r_a <= w_right;
                r_b <= w_left;
            end else begin
                r_a <= w_left;
                r_b <= w_right;
            end
        end
        if (r_state == ST_PMUL || r_state == ST_HMUL) begin
            r_prod <= w_mul_p[63:0];
        end
        if (r_state == ST_PADD) begin
            r_acc <= r_coef_cubic;
            if (r_target) begin
                r_x1 <= w_probe;
            end else begin
                r_x0 <= w_probe;
            end
        end
        if (r_state == ST_HADD) begin
            r_acc <= w_hval;
            if (w_hsat) begin
                r_sat <= 1'b1;
            end
            if (r_step == STEP_CONSTANT) begin
                if (r_target) begin
                    r_f1 <= w_hval;
                end else begin
                    r_f0 <= w_hval;
                end
            end
        end
        // Keep one probe and its value, shrink the interval past the other.
        if (r_state == ST_DECIDE && r_iter != '0) begin
            if (w_move_left) begin
                r_a  <= r_x0;
                r_x0 <= r_x1;
                r_f0 <= r_f1;
            end else begin
                r_b  <= r_x1;
                r_x1 <= r_x0;
                r_f1 <= r_f0;
            end
        end
        if (r_state == ST_DONE && w_out_free) begin
            r_m_data <= {7'd0, r_sat, r_f1, r_x1};
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // A running search never lets the interval turn around.
    a_interval_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_a <= r_b))
        else $error("search interval bounds out of order");

    // An accepted interval blocks the input until its search finishes.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("input ready while a search is running");

    // A new result appears only as the sequencer leaves its final state.
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == ST_DONE))
        else $error("result valid without a finished search");

    // Horner steps never run past the constant term.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HMUL || r_state == ST_HADD) |-> (r_step != 2'd3))
        else $error("Horner step out of range");

endmodule
